/* sv/assert_macros.svh */
// Assertion helper macros shared by the RTL of the byte signature search.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(name, clk_sig, rst_sig, prop, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define ASSERT_CLK(name, clk_sig, prop, msg) \
  name: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(name, clk_sig, rst_sig, prop, msg)
`define ASSERT_CLK(name, clk_sig, prop, msg)
`endif
`endif

/* sv/wbps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte signature search.
// Used by wbps_cfg, wbps_match and the top level; depends on nothing.
package wbps_pkg;

  localparam int REG_BYTES = 16;
  localparam int PATTERN_MAX_DEF = 16;
  localparam longint MAX_BLOCK_BYTES_DEF = 64'd65536;
  localparam int LEN_W = 5;
  localparam int CARE_W = 16;
  localparam int REG_W = 64;
  localparam int OFFSET_W = 16;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 16'hFFFF;

  localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PAT_LO = 2'd0,
    CFG_PAT_HI = 2'd1,
    CFG_CARE   = 2'd2,
    CFG_LEN    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0]  pat_hi;
    logic [REG_W-1:0]  pat_lo;
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  length;
  } cfg_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_t;

endpackage

/* sv/wbps_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file: pattern bytes, care mask and pattern length.
// Depends on wbps_pkg.
module wbps_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  wbps_pkg::cfg_idx_t          cfg_addr,
  input  logic [wbps_pkg::REG_W-1:0]  cfg_data,
  output wbps_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pat_lo <= '0;
      cfg.pat_hi <= '0;
      cfg.care   <= wbps_pkg::CARE_RESET;
      cfg.length <= wbps_pkg::LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wbps_pkg::CFG_PAT_LO: cfg.pat_lo <= cfg_data;
        wbps_pkg::CFG_PAT_HI: cfg.pat_hi <= cfg_data;
        wbps_pkg::CFG_CARE:   cfg.care   <= cfg_data[wbps_pkg::CARE_W-1:0];
        wbps_pkg::CFG_LEN:    cfg.length <= cfg_data[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/wbps_match.sv */
`timescale 1ns / 1ps
// Byte history window, block byte counter and the masked signature compare.
// Depends on wbps_pkg; driven by the top level once per registered byte.
module wbps_match #(
  parameter int     PATTERN_MAX     = wbps_pkg::PATTERN_MAX_DEF,
  parameter longint MAX_BLOCK_BYTES = wbps_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         cur_byte,
  input  logic               cur_last,
  input  wbps_pkg::cfg_t     cfg,
  output logic               res_valid,
  output wbps_pkg::result_t  res
);

  localparam int LIM   = (PATTERN_MAX < wbps_pkg::REG_BYTES) ? PATTERN_MAX
                                                            : wbps_pkg::REG_BYTES;
  localparam int WIN   = LIM - 1;
  localparam int IW    = $clog2(LIM);
  localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);

  logic [7:0]       window [WIN];
  logic [CNT_W-1:0] cnt;
  logic             reported;

  logic [wbps_pkg::LEN_W-1:0] len;
  logic [7:0]                 hist [LIM];
  logic [2*wbps_pkg::REG_W-1:0] pat;
  logic                       hit;
  logic [CNT_W:0]             cnt_p1;
  logic [CNT_W:0]             start;
  logic                       found_now;

  always_comb begin
    len = cfg.length;
    if (len == '0) begin
      len = wbps_pkg::LEN_W'(1);
    end else if (len > wbps_pkg::LEN_W'(LIM)) begin
      len = wbps_pkg::LEN_W'(LIM);
    end
  end

  // hist[d] is the byte d positions before the current one.
  always_comb begin
    hist[0] = cur_byte;
    for (int k = 1; k < LIM; k++) begin
      hist[k] = window[k-1];
    end
  end

  assign pat = {cfg.pat_hi, cfg.pat_lo};

  // Pattern byte i lines up with the byte len-1-i positions back.
  always_comb begin
    logic [wbps_pkg::LEN_W-1:0] d;
    hit = 1'b1;
    for (int i = 0; i < LIM; i++) begin
      d = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i);
      if (wbps_pkg::LEN_W'(i) < len && cfg.care[i] &&
          hist[d[IW-1:0]] != pat[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  assign cnt_p1    = {1'b0, cnt} + (CNT_W+1)'(1);
  assign start     = cnt_p1 - (CNT_W+1)'(len);
  assign found_now = !reported && (cnt_p1 >= (CNT_W+1)'(len)) && hit;

  always_comb begin
    res_valid  = found_now || (cur_last && !reported);
    res.found  = found_now;
    res.offset = '0;
    if (found_now) begin
      if (start > (CNT_W+1)'(wbps_pkg::OFFSET_MAX)) begin
        res.offset = wbps_pkg::OFFSET_MAX;
      end else begin
        res.offset = wbps_pkg::OFFSET_W'(start);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      reported <= 1'b0;
      for (int k = 0; k < WIN; k++) begin
        window[k] <= '0;
      end
    end else if (step) begin
      if (cur_last) begin
        cnt      <= '0;
        reported <= 1'b0;
        for (int k = 0; k < WIN; k++) begin
          window[k] <= '0;
        end
      end else begin
        if (found_now) begin
          reported <= 1'b1;
        end
        if (cnt != CNT_W'(MAX_BLOCK_BYTES)) begin
          cnt <= cnt_p1[CNT_W-1:0];
        end
        window[0] <= cur_byte;
        for (int k = 1; k < WIN; k++) begin
          window[k] <= window[k-1];
        end
      end
    end
  end

endmodule

/* sv/wildcard_byte_pattern_search_core.sv */
`timescale 1ns / 1ps
// A byte is held in the input register, and its result then in the output register on m_t*.
// Throughput: one byte per cycle; the input register stalls only while the output
// register holds a result the sink has not taken.
// Reset (rst, synchronous, active high) clears the window, the byte counter, the
// match flag, the valid flags of both register stages and the configuration to its reset values.
`include "assert_macros.svh"

module wildcard_byte_pattern_search_core #(
  parameter int     PATTERN_MAX     = wbps_pkg::PATTERN_MAX_DEF,
  parameter longint MAX_BLOCK_BYTES = wbps_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  wbps_pkg::cfg_idx_t          cfg_addr,
  input  logic [wbps_pkg::REG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [15:0] match_offset
  output logic                        m_tuser    // found
);

  wbps_pkg::cfg_t    cfg;
  wbps_pkg::result_t res;
  logic              res_valid;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       adv;
  logic       step;

  wbps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // The registered byte moves on whenever the output register is free or draining.
  assign adv      = !m_tvalid || m_tready;
  assign step     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  wbps_match #(
    .PATTERN_MAX     (PATTERN_MAX),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cur_byte  (in_byte),
    .cur_last  (in_last),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      m_tdata <= res.offset;
      m_tuser <= res.found;
    end
  end

  `ASSERT_CLK_RST(a_notfound_zero, clk, rst, (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0), "not-found result carries a nonzero offset")
  `ASSERT_CLK_RST(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready, "input stalled while the output register is empty")
  `ASSERT_CLK_RST(a_stall_cause, clk, rst, !s_tready |-> (in_valid && m_tvalid && !m_tready), "input stalled without a blocked result")
  `ASSERT_CLK_RST(a_result_source, clk, rst, $rose(m_tvalid) |-> $past(in_valid), "result appeared with no byte in the input register")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for wildcard_byte_pattern_search_core: a short stimulus table, then
// random blocks under random signatures, checked against the table's expected results or an in-bench signature matcher.
// Depends on wbps_pkg and the core RTL only.
module tb;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    wbps_pkg::cfg_idx_t         idx;
    logic [wbps_pkg::REG_W-1:0] value;   // register value, or the data byte in [7:0]
    logic                       is_last;
    logic                       typed;   // 1: the result below is the one to expect
    wbps_pkg::result_t          want;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;
  localparam int SIG_MAX = (wbps_pkg::PATTERN_MAX_DEF < wbps_pkg::REG_BYTES) ?
                           wbps_pkg::PATTERN_MAX_DEF : wbps_pkg::REG_BYTES;
  localparam int OFFSET_SAT = 65535;
  localparam int SEEN_SAT = 65536;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  wbps_pkg::cfg_idx_t         cfg_addr = wbps_pkg::CFG_PAT_LO;
  logic [wbps_pkg::REG_W-1:0] cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata = '0;     // [7:0] data_byte
  logic                       s_tlast = 1'b0;   // last_byte
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [15:0]                m_tdata;          // [15:0] match_offset
  logic                       m_tuser;          // found

  // Shadow copy of the configuration and of the search state.
  logic [wbps_pkg::REG_W-1:0]  sig_lo = '0;
  logic [wbps_pkg::REG_W-1:0]  sig_hi = '0;
  logic [wbps_pkg::CARE_W-1:0] sig_care = wbps_pkg::CARE_RESET;
  logic [wbps_pkg::LEN_W-1:0]  sig_len_reg = wbps_pkg::LEN_RESET;
  logic [7:0]                  history_q [SIG_MAX];
  int unsigned                 seen_cnt = 0;
  bit                          already_hit = 1'b0;

  wbps_pkg::result_t awaited_hits [$];
  int                mismatches = 0;
  int                burst_left = 0;
  int                bytes_sent = 0;
  bit                hold_off_req = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h00, 1'b1, 1'b1, '{1'b1, 16'd0}},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b1, 1'b1, '{1'b0, 16'd0}},
    '{ROW_WRITE, wbps_pkg::CFG_PAT_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_LEN,    64'd0, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h12, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b1, 1'b1, '{1'b1, 16'd1}},
    '{ROW_WRITE, wbps_pkg::CFG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_CARE,   64'h0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_LEN,    64'd31, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h80, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h01, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h7F, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFE, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h55, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hAA, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h0F, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hF0, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h33, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hCC, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h00, 1'b0, 1'b0, '0},
    // Sixteenth byte of an all-wildcard signature ends the block as well.
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b1, 1'b1, '{1'b1, 16'd0}},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hFF, 1'b1, 1'b1, '{1'b0, 16'd0}},
    // The signature changes between the two bytes of this block.
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'hAA, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_PAT_LO, 64'h55AA, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_CARE,   64'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, wbps_pkg::CFG_LEN,    64'd2, 1'b0, 1'b0, '0},
    '{ROW_BYTE,  wbps_pkg::CFG_PAT_LO, 64'h55, 1'b1, 1'b1, '{1'b1, 16'd0}}
  };

  wildcard_byte_pattern_search_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("wildcard_byte_pattern_search_core verification failed");
    $finish;
  end

  function automatic int sig_len();
    int len;
    len = sig_len_reg;
    if (len == 0) len = 1;
    if (len > SIG_MAX) len = SIG_MAX;
    return len;
  endfunction

  function automatic logic [7:0] sig_byte(input int i);
    if (i < 8) return sig_lo[8*i +: 8];
    return sig_hi[8*(i-8) +: 8];
  endfunction

  // Advances the shadow search by one byte; returns 1 when the byte yields a result.
  function automatic bit search_byte(input logic [7:0] cur, input bit last,
                                     output wbps_pkg::result_t res);
    int len;
    int start;
    bit hit;
    bit produced;
    logic [7:0] seen_byte;
    len = sig_len();
    produced = 1'b0;
    res = '0;
    if (!already_hit && seen_cnt + 1 >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        seen_byte = (i == len - 1) ? cur : history_q[len - 2 - i];
        if (sig_care[i] && seen_byte != sig_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        start = seen_cnt + 1 - len;
        if (start > OFFSET_SAT) start = OFFSET_SAT;
        res.found = 1'b1;
        res.offset = start[15:0];
        already_hit = 1'b1;
        produced = 1'b1;
      end
    end
    if (last) begin
      if (!already_hit) begin
        res = '0;
        produced = 1'b1;
      end
      foreach (history_q[i]) history_q[i] = '0;
      seen_cnt = 0;
      already_hit = 1'b0;
    end else begin
      for (int i = SIG_MAX - 1; i > 0; i--) history_q[i] = history_q[i-1];
      history_q[0] = cur;
      if (seen_cnt < SEEN_SAT) seen_cnt++;
    end
    return produced;
  endfunction

  // Offers one byte; the sender works in bursts with random gaps between them.
  task automatic put_byte(input logic [7:0] d, input bit last, input bit typed,
                          input wbps_pkg::result_t want);
    int gap;
    wbps_pkg::result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (search_byte(d, last, res)) awaited_hits.push_back(typed ? want : res);
  endtask

  // Drains the block before touching its registers.
  task automatic go_quiet();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_hits.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input wbps_pkg::cfg_idx_t idx,
                           input logic [wbps_pkg::REG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      wbps_pkg::CFG_PAT_LO: sig_lo = value;
      wbps_pkg::CFG_PAT_HI: sig_hi = value;
      wbps_pkg::CFG_CARE:   sig_care = value[wbps_pkg::CARE_W-1:0];
      wbps_pkg::CFG_LEN:    sig_len_reg = value[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic pick_signature();
    logic [wbps_pkg::REG_W-1:0]  lo;
    logic [wbps_pkg::REG_W-1:0]  hi;
    logic [wbps_pkg::CARE_W-1:0] care;
    logic [wbps_pkg::LEN_W-1:0]  len;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: lo = '0;
      1: lo = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: hi = '0;
      1: hi = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: care = '0;
      1: care = '1;
      2: care = 16'($urandom) | 16'($urandom);
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'($urandom_range(17, 31));
      3: len = 5'd1;
      default: len = 5'($urandom_range(2, 15));
    endcase
    go_quiet();
    write_reg(wbps_pkg::CFG_PAT_LO, lo);
    write_reg(wbps_pkg::CFG_PAT_HI, hi);
    write_reg(wbps_pkg::CFG_CARE, {48'd0, care});
    write_reg(wbps_pkg::CFG_LEN, {59'd0, len});
  endtask

  // One block of random bytes, usually with a copy of the signature planted in it.
  // Some copies are cut off by the end of the block or carry a flipped byte.
  task automatic send_block();
    logic [7:0] blk [$];
    int blen;
    int p;
    int len;
    int k;
    bit skewed;
    len = sig_len();
    blen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    skewed = ($urandom_range(0, 2) != 0);
    for (k = 0; k < blen; k++) begin
      if (skewed && $urandom_range(0, 1) == 1)
        blk.push_back(sig_byte($urandom_range(0, len - 1)));
      else
        blk.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 4) == 0 || blen <= len) p = $urandom_range(0, blen);
      else p = $urandom_range(0, blen - len);
      for (k = 0; k < len; k++)
        if (p + k < blen && sig_care[k]) blk[p+k] = sig_byte(k);
      if ($urandom_range(0, 4) == 0) begin
        k = p + $urandom_range(0, len - 1);
        if (k < blen) blk[k] = blk[k] ^ 8'h01;
      end
    end
    for (k = 0; k < blen; k++) put_byte(blk[k], k == blen - 1, 1'b0, '0);
  endtask

  // The receiver stalls on a pattern of its own, and once holds off for a long stretch.
  initial begin
    int mode;
    int span;
    int phase;
    bit ready;
    phase = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        phase++;
        case (mode)
          0: ready = 1'b1;
          1: ready = $urandom_range(0, 1);
          2: ready = ($urandom_range(0, 3) == 0);
          default: ready = (phase % 5) < 3;
        endcase
        m_tready <= ready;
      end
    end
  end

  always @(posedge clk) begin
    wbps_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_hits.size() == 0) begin
        $display("%0t: result with none expected: found=%0b offset=%0d",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = awaited_hits.pop_front();
        if (m_tuser !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
          mismatches++;
        end
        if (m_tdata !== want.offset) begin
          $display("%0t: offset expected %0d actual %0d", $time, want.offset, m_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int phase_end;
    foreach (history_q[i]) history_q[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        go_quiet();
        write_reg(plan[r].idx, plan[r].value);
      end else begin
        put_byte(plan[r].value[7:0], plan[r].is_last, plan[r].typed, plan[r].want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      pick_signature();
      if (ph == 2) hold_off_req = 1'b1;
      phase_end = bytes_sent + 110;
      while (bytes_sent < phase_end) send_block();
    end

    go_quiet();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("wildcard_byte_pattern_search_core verification clean");
    end else begin
      $display("wildcard_byte_pattern_search_core verification failed");
    end
    $finish;
  end

endmodule
